>>> design/sieve_pkg.sv
// ----------------------------------------------------------------------------
// sieve_pkg
// Shared types and constants for the prime sieve table engine.
// ----------------------------------------------------------------------------
package sieve_pkg;

    localparam int MAX_NUMBER = 65536;
    localparam int NUM_W      = 16;
    localparam int LIM_W      = 17;
    localparam int BASE_W     = 9;

    typedef enum logic
    {
        CMD_BUILD = 1'b0,
        CMD_QUERY = 1'b1
    } cmd_t;

    typedef enum logic [1:0]
    {
        ST_OK        = 2'd0,
        ST_RANGE     = 2'd1,
        ST_NOT_BUILT = 2'd2
    } status_t;

    typedef struct packed
    {
        cmd_t             cmd;
        logic [NUM_W-1:0] number;
    } item_t;

    typedef struct packed
    {
        logic    is_prime;
        status_t status;
    } result_t;

    typedef enum logic [2:0]
    {
        OP_NONE,
        OP_FILL_INIT,
        OP_FILL,
        OP_BASE_RD,
        OP_BASE_NEXT,
        OP_CROSS_INIT,
        OP_CROSS,
        OP_QUERY
    } dp_op_t;

    typedef struct packed
    {
        dp_op_t op;
        logic   table_ready;
    } dp_cmd_t;

    typedef struct packed
    {
        logic fill_last;
        logic sq_ge_lim;
        logic base_prime;
        logic m_ge_lim;
    } dp_stat_t;

endpackage

>>> design/sieve_ram.sv
// ----------------------------------------------------------------------------
// sieve_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sieve_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> design/sieve_dp.sv
// ----------------------------------------------------------------------------
// sieve_dp
// Datapath: limit register, fill/base/multiple counters, flag table and
// query result registers.
// ----------------------------------------------------------------------------
module sieve_dp (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [sieve_pkg::LIM_W-1:0]      cfg_data,
    input  sieve_pkg::item_t                 item,
    input  sieve_pkg::dp_cmd_t               cmd,
    output sieve_pkg::dp_stat_t              stat,
    output logic                             q_valid,
    output sieve_pkg::result_t               q_result
);
    import sieve_pkg::*;

    logic [LIM_W-1:0]  limit_reg;
    logic [NUM_W-1:0]  n_reg, n_next;
    logic [BASE_W-1:0] b_reg, b_next;
    logic [LIM_W-1:0]  sq_reg, sq_next;
    logic [LIM_W-1:0]  m_reg, m_next;
    logic              q_valid_reg, q_valid_next;
    status_t           q_status_reg, q_status_next;

    logic [LIM_W-1:0]  lim;
    logic [LIM_W-1:0]  fill_end;
    logic              ram_we;
    logic [NUM_W-1:0]  ram_waddr;
    logic              ram_wdata;
    logic              ram_re;
    logic [NUM_W-1:0]  ram_raddr;
    logic              ram_rdata;

    // limit saturates at the table size
    assign lim      = (limit_reg > LIM_W'(MAX_NUMBER)) ? LIM_W'(MAX_NUMBER) : limit_reg;
    // entries 0 and 1 are always written, even for a tiny limit
    assign fill_end = (lim < LIM_W'(2)) ? LIM_W'(2) : lim;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg   <= LIM_W'(MAX_NUMBER);
            q_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                limit_reg <= cfg_data;
            end
            q_valid_reg <= q_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg        <= n_next;
        b_reg        <= b_next;
        sq_reg       <= sq_next;
        m_reg        <= m_next;
        q_status_reg <= q_status_next;
    end

    always_comb
    begin
        n_next        = n_reg;
        b_next        = b_reg;
        sq_next       = sq_reg;
        m_next        = m_reg;
        q_valid_next  = 1'b0;
        q_status_next = q_status_reg;
        case (cmd.op)
            OP_FILL_INIT:
            begin
                n_next  = '0;
                b_next  = BASE_W'(2);
                sq_next = LIM_W'(4);
            end
            OP_FILL:
            begin
                n_next = n_reg + NUM_W'(1);
            end
            OP_BASE_NEXT:
            begin
                // (b+1)^2 = b^2 + 2b + 1
                b_next  = b_reg + BASE_W'(1);
                sq_next = sq_reg + LIM_W'({b_reg, 1'b0}) + LIM_W'(1);
            end
            OP_CROSS_INIT:
            begin
                m_next = sq_reg;
            end
            OP_CROSS:
            begin
                m_next = m_reg + LIM_W'(b_reg);
            end
            OP_QUERY:
            begin
                q_valid_next = 1'b1;
                if (!cmd.table_ready)
                begin
                    q_status_next = ST_NOT_BUILT;
                end
                else if ({1'b0, item.number} >= lim)
                begin
                    q_status_next = ST_RANGE;
                end
                else
                begin
                    q_status_next = ST_OK;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign ram_we    = (cmd.op == OP_FILL) || (cmd.op == OP_CROSS);
    assign ram_waddr = (cmd.op == OP_FILL) ? n_reg : m_reg[NUM_W-1:0];
    assign ram_wdata = (cmd.op == OP_FILL) ? (n_reg >= NUM_W'(2)) : 1'b0;
    assign ram_re    = (cmd.op == OP_QUERY) || (cmd.op == OP_BASE_RD);
    assign ram_raddr = (cmd.op == OP_QUERY) ? item.number : NUM_W'(b_reg);

    sieve_ram #(
        .WIDTH (1),
        .DEPTH (MAX_NUMBER)
    ) u_flags (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign stat.fill_last  = ({1'b0, n_reg} == (fill_end - LIM_W'(1)));
    assign stat.sq_ge_lim  = (sq_reg >= lim);
    assign stat.base_prime = ram_rdata;
    assign stat.m_ge_lim   = (m_reg >= lim);

    assign q_valid           = q_valid_reg;
    assign q_result.is_prime = (q_status_reg == ST_OK) & ram_rdata;
    assign q_result.status   = q_status_reg;

endmodule

>>> design/sieve_ctrl.sv
// ----------------------------------------------------------------------------
// sieve_ctrl
// Controller: sequences the table fill and the crossing-out passes, and
// tracks whether a table has been built.
// ----------------------------------------------------------------------------
module sieve_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  sieve_pkg::cmd_t      item_cmd,
    input  sieve_pkg::dp_stat_t  stat,
    output sieve_pkg::dp_cmd_t   cmd,
    output logic                 busy,
    output logic                 build_done
);
    import sieve_pkg::*;

    typedef enum logic [2:0]
    {
        S_IDLE,
        S_FILL,
        S_BASE_TEST,
        S_BASE_CHK,
        S_CROSS
    } state_t;

    state_t state_reg, state_next;
    logic   ready_reg, ready_next;
    logic   build_done_reg, build_done_next;
    dp_op_t op;

    always_comb
    begin
        state_next      = state_reg;
        ready_next      = ready_reg;
        build_done_next = 1'b0;
        op              = OP_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (item_cmd == CMD_BUILD)
                    begin
                        op         = OP_FILL_INIT;
                        state_next = S_FILL;
                    end
                    else
                    begin
                        op = OP_QUERY;
                    end
                end
            end
            S_FILL:
            begin
                op = OP_FILL;
                if (stat.fill_last)
                begin
                    state_next = S_BASE_TEST;
                end
            end
            S_BASE_TEST:
            begin
                if (stat.sq_ge_lim)
                begin
                    ready_next      = 1'b1;
                    build_done_next = 1'b1;
                    state_next      = S_IDLE;
                end
                else
                begin
                    op         = OP_BASE_RD;
                    state_next = S_BASE_CHK;
                end
            end
            S_BASE_CHK:
            begin
                // flag of the base is on the ram output now
                if (stat.base_prime)
                begin
                    op         = OP_CROSS_INIT;
                    state_next = S_CROSS;
                end
                else
                begin
                    op         = OP_BASE_NEXT;
                    state_next = S_BASE_TEST;
                end
            end
            S_CROSS:
            begin
                if (stat.m_ge_lim)
                begin
                    op         = OP_BASE_NEXT;
                    state_next = S_BASE_TEST;
                end
                else
                begin
                    op = OP_CROSS;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            ready_reg      <= 1'b0;
            build_done_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            ready_reg      <= ready_next;
            build_done_reg <= build_done_next;
        end
    end

    assign cmd.op          = op;
    assign cmd.table_ready = ready_reg;
    assign busy            = (state_reg != S_IDLE);
    assign build_done      = build_done_reg;

endmodule

>>> design/prime_sieve_table.sv
// Query: result in the cycle after start; one query beat accepted every cycle
// while busy is low. Build: busy while it fills max(limit,2) entries, then
// tests each base b with b*b < limit, crosses out the multiples of each prime
// base and ends with a closing test; the build result beat comes in the first
// cycle busy is low. Reset clears the build flag and sets the limit to 65536;
// the flag table is not cleared. Results cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
// prime_sieve_table
// Sieve of Eratosthenes engine with a one-bit-per-number flag table.
// ----------------------------------------------------------------------------
module prime_sieve_table (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  sieve_pkg::item_t              item,
    output logic                          busy,
    output logic                          done,
    output sieve_pkg::result_t            result,
    input  logic                          cfg_we,
    input  logic [sieve_pkg::LIM_W-1:0]   cfg_data
);
    import sieve_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;
    logic     build_done;
    logic     q_valid;
    result_t  q_result;

    sieve_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .item_cmd   (item.cmd),
        .stat       (stat),
        .cmd        (cmd),
        .busy       (busy),
        .build_done (build_done)
    );

    sieve_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .item     (item),
        .cmd      (cmd),
        .stat     (stat),
        .q_valid  (q_valid),
        .q_result (q_result)
    );

    // a build beat and a query beat never land in the same cycle
    assign done = build_done | q_valid;
    assign result = q_valid ? q_result : result_t'{is_prime: 1'b0, status: ST_OK};

    a_query_answers: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && item.cmd == CMD_QUERY) |=> done)
        else $error("query beat not answered in the next cycle");

    a_build_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && item.cmd == CMD_BUILD) |=> (busy && !build_done))
        else $error("build accepted but engine not busy");

    a_bad_status_not_prime: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status != ST_OK) |-> !result.is_prime)
        else $error("prime flag set on a failed query");

    a_single_beat: assert property (@(posedge clk) disable iff (!rst_n)
        !(build_done && q_valid))
        else $error("build and query beats collide");

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench for prime_sieve_table. Build and query beats are predicted by a
// behavioral sieve over a shadow flag table. Each result beat is checked
// against the oldest outstanding answer as it arrives.
// ----------------------------------------------------------------------------
module tb;

    import sieve_pkg::*;

    localparam int CYCLE_LIMIT  = 4_000_000;
    localparam int TOTAL_ITEMS  = 1700;
    localparam int CALM_TAIL    = 250;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             start;
    item_t            item;
    logic             busy;
    logic             done;
    result_t          result;
    logic             cfg_we;
    logic [LIM_W-1:0] cfg_data;

    // shadow of the engine
    logic [LIM_W-1:0] limit_shadow = 17'd65536;
    bit               prime_map [MAX_NUMBER];
    bit               table_built  = 1'b0;
    int               written_top  = 0;

    result_t     pending_answers [$];
    int          err_count   = 0;
    int          idle_pct    = 0;
    int          items_sent  = 0;
    int unsigned cycle_count = 0;

    always #6 clk = ~clk;

    prime_sieve_table dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .item     (item),
        .busy     (busy),
        .done     (done),
        .result   (result),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data)
    );

    function automatic int active_limit();
        return (limit_shadow > MAX_NUMBER) ? MAX_NUMBER : int'(limit_shadow);
    endfunction

    function automatic void run_sieve();
        int lim;
        int n;
        int b;
        int m;
        lim = active_limit();
        for (n = 2; n < lim; n++)
            prime_map[n] = 1'b1;
        prime_map[0] = 1'b0;
        prime_map[1] = 1'b0;
        for (b = 2; b * b < lim; b++)
        begin
            if (prime_map[b])
            begin
                for (m = b * b; m < lim; m += b)
                    prime_map[m] = 1'b0;
            end
        end
        table_built = 1'b1;
        if (((lim < 2) ? 2 : lim) > written_top)
            written_top = (lim < 2) ? 2 : lim;
    endfunction

    function automatic result_t sieve_answer(input item_t it);
        result_t r;
        r.is_prime = 1'b0;
        r.status   = ST_OK;
        if (it.cmd == CMD_BUILD)
            run_sieve();
        else if (!table_built)
            r.status = ST_NOT_BUILT;
        else if (int'(it.number) >= active_limit())
            r.status = ST_RANGE;
        else
            r.is_prime = prime_map[it.number];
        return r;
    endfunction

    // mix of full-range, in-range and boundary numbers
    function automatic logic [NUM_W-1:0] pick_number();
        int lim;
        int n;
        lim = active_limit();
        case ($urandom_range(3, 0))
            0:       n = $urandom_range(65535, 0);
            1, 2:    n = $urandom_range((lim > 0) ? lim - 1 : 0, 0);
            default: n = lim - 1 + $urandom_range(2, 0);
        endcase
        if (n < 0)
            n = 0;
        if (n > 65535)
            n = 65535;
        // entries that no build has reached hold nothing defined
        if (table_built && n < lim && n >= written_top)
            n = n % written_top;
        return n[NUM_W-1:0];
    endfunction

    // called and returns at a falling edge
    task automatic send_item(input cmd_t op, input logic [NUM_W-1:0] num);
        item_t it;
        it.cmd    = op;
        it.number = num;
        if (idle_pct > 0 && $urandom_range(99, 0) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(4, 1)) @(negedge clk);
        end
        start <= 1'b1;
        item  <= it;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_answers.push_back(sieve_answer(it));
        items_sent++;
        @(negedge clk);
    endtask

    task automatic write_limit(input logic [LIM_W-1:0] value);
        start <= 1'b0;
        while (pending_answers.size() != 0)
            @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        limit_shadow = value;
    endtask

    task automatic test_query_before_build();
        send_item(CMD_QUERY, 16'd0);
        send_item(CMD_QUERY, 16'hFFFF);
        send_item(CMD_QUERY, 16'd2);
    endtask

    // build with the limit left by reset
    task automatic test_full_table();
        int probes [6] = '{0, 1, 2, 4, 65521, 65535};
        send_item(CMD_BUILD, 16'hFFFF);
        foreach (probes[i])
            send_item(CMD_QUERY, probes[i][NUM_W-1:0]);
    endtask

    task automatic test_limit_edges();
        // limit below two still clears entries 0 and 1
        write_limit(17'd0);
        send_item(CMD_BUILD, 16'd0);
        send_item(CMD_QUERY, 16'd1);
        send_item(CMD_QUERY, 16'd2);
        write_limit(17'd3);
        send_item(CMD_BUILD, 16'd0);
        send_item(CMD_QUERY, 16'd2);
        // raised limit reads what the earlier full build left
        write_limit(17'd100);
        send_item(CMD_BUILD, 16'h5555);
        write_limit(17'd1000);
        send_item(CMD_QUERY, 16'd997);
        // all ones saturates at the table size
        write_limit(17'h1FFFF);
        send_item(CMD_QUERY, 16'hFFFF);
        send_item(CMD_BUILD, 16'hAAAA);
        send_item(CMD_QUERY, 16'd65521);
    endtask

    task automatic test_random_traffic();
        logic [LIM_W-1:0] lim;
        int               phase_len;
        int               k;
        while (items_sent < TOTAL_ITEMS)
        begin
            case ($urandom_range(9, 0))
                0:       lim = 17'($urandom_range(3, 0));
                1:       lim = 17'($urandom_range(8192, 2049));
                default: lim = 17'($urandom_range(2048, 4));
            endcase
            case ($urandom_range(2, 0))
                0:       idle_pct = 0;
                1:       idle_pct = 25;
                default: idle_pct = 60;
            endcase
            write_limit(lim);
            // sometimes query the previous table under the new limit first
            if ($urandom_range(2, 0) != 0)
                send_item(CMD_BUILD, 16'($urandom));
            phase_len = $urandom_range(180, 60);
            for (k = 0; k < phase_len && items_sent < TOTAL_ITEMS; k++)
            begin
                if (TOTAL_ITEMS - items_sent <= CALM_TAIL)
                    idle_pct = 0;
                if ($urandom_range(99, 0) < 2)
                    send_item(CMD_BUILD, 16'($urandom));
                else
                    send_item(CMD_QUERY, pick_number());
            end
        end
    endtask

    always @(posedge clk)
    begin : answer_check
        result_t want;
        if (rst_n && done)
        begin
            if (pending_answers.size() == 0)
            begin
                $error("result beat with no build or query outstanding");
                err_count++;
            end
            else
            begin
                want = pending_answers.pop_front();
                if (result.is_prime !== want.is_prime)
                begin
                    $error("is_prime: expected %0d, actual %0d", want.is_prime, result.is_prime);
                    err_count++;
                end
                if (result.status !== want.status)
                begin
                    $error("status: expected %0d, actual %0d", want.status, result.status);
                    err_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        rst_n    = 1'b0;
        start    = 1'b0;
        item     = '0;
        cfg_we   = 1'b0;
        cfg_data = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        idle_pct = 25;
        test_query_before_build();
        test_full_table();
        test_limit_edges();
        test_random_traffic();

        start <= 1'b0;
        while (pending_answers.size() != 0)
            @(negedge clk);
        repeat (16) @(negedge clk);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
